// ===== sv/bgh_pkg.sv =====
// ----------------------------------------------------------------------------
// bgh_pkg
// Widths, band thresholds, level codes and LED settings for the battery
// level gauge.
// ----------------------------------------------------------------------------
package bgh_pkg;

	localparam int unsigned SAMPLE_W = 12;
	localparam int unsigned LEVEL_W  = 3;
	localparam int unsigned BLINK_W  = 4;

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [LEVEL_W-1:0]  level_t;
	typedef logic [BLINK_W-1:0]  blink_t;

	// reset value of the drop reject limit
	localparam sample_t LIMIT_RST = 12'h200;

	// band thresholds, lower bound inclusive, upper bound exclusive
	localparam sample_t TH_FULL   = 12'd1921;
	localparam sample_t TH_L1_HI  = 12'd1911;
	localparam sample_t TH_L1_LO  = 12'd1849;
	localparam sample_t TH_L2_HI  = 12'd1839;
	localparam sample_t TH_L2_LO  = 12'd1778;
	localparam sample_t TH_L3_HI  = 12'd1768;
	localparam sample_t TH_L3_LO  = 12'd1706;
	localparam sample_t TH_L4_HI  = 12'd1696;
	localparam sample_t TH_L4_LO  = 12'd1634;
	localparam sample_t TH_OFF_HI = 12'd1624;

	// level codes
	localparam level_t LVL_FULL = 3'd0;
	localparam level_t LVL_75   = 3'd1;
	localparam level_t LVL_50   = 3'd2;
	localparam level_t LVL_25   = 3'd3;
	localparam level_t LVL_10   = 3'd4;
	localparam level_t LVL_OFF  = 3'd5;

	// blink settings
	localparam blink_t BLINK_NONE = 4'd0;
	localparam blink_t BLINK_FAST = 4'd2;
	localparam blink_t BLINK_SLOW = 4'd10;

endpackage

// ===== sv/bgh_if.sv =====
// ----------------------------------------------------------------------------
// bgh_in_if / bgh_out_if
// Valid/ready channels for battery samples and gauge results.
// ----------------------------------------------------------------------------
interface bgh_in_if import bgh_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t sample;
	logic    charging;
	logic    discharge_latched;
	logic    led_suppress;

	modport source (output valid, sample, charging, discharge_latched, led_suppress,
		input ready);
	modport sink (input valid, sample, charging, discharge_latched, led_suppress,
		output ready);
endinterface

interface bgh_out_if import bgh_pkg::*; ();
	logic    valid;
	logic    ready;
	level_t  level;
	logic    report;
	sample_t filtered_value;
	logic    red_on;
	logic    green_on;
	blink_t  blink_period;
	logic    led_enable;
	logic    low_warning;

	modport source (output valid, level, report, filtered_value, red_on, green_on,
		blink_period, led_enable, low_warning, input ready);
	modport sink (input valid, level, report, filtered_value, red_on, green_on,
		blink_period, led_enable, low_warning, output ready);
endinterface

// ===== sv/battery_level_gauge_with_hysteresis.sv =====
// ----------------------------------------------------------------------------
// battery_level_gauge_with_hysteresis
// Filters battery samples, sorts the reading into six levels with
// hysteresis gaps and drives the LED indication from the level.
// ----------------------------------------------------------------------------
// a result is valid in the cycle after its request is accepted
// throughput: one request per cycle; the state registers double as the
//   result register, so a new request is taken whenever the result is free
//   or being taken in the same cycle
// reset: filtered value 0, level 2, LEDs off, reject limit 512, no result
module battery_level_gauge_with_hysteresis import bgh_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  sample_t         cfg_wdata,
	bgh_in_if.sink          adc,
	bgh_out_if.source       gauge
);

	sample_t limit_q;
	sample_t running_q;
	level_t  level_q;
	logic    report_q;
	logic    red_q;
	logic    green_q;
	blink_t  blink_q;
	logic    enable_q;
	logic    warning_q;
	logic    valid_q;

	logic    accept;
	sample_t running_d;
	level_t  level_d;
	logic    report_d;
	logic    red_d;
	logic    green_d;
	blink_t  blink_d;
	logic    enable_d;
	logic    warning_d;
	logic    [SAMPLE_W:0] sum;
	logic    chg;

	assign adc.ready = !valid_q || gauge.ready;
	assign accept    = adc.valid && adc.ready;
	assign chg       = adc.charging;

	// running value filter with drop rejection
	always_comb begin
		sum = {1'b0, running_q} + {1'b0, adc.sample};
		if (running_q == '0) begin
			running_d = adc.sample;
		end else if (running_q < adc.sample || (running_q - adc.sample) < limit_q) begin
			running_d = sum[SAMPLE_W:1];
		end else begin
			running_d = running_q;
		end
	end

	// band selection with hysteresis
	always_comb begin
		level_d  = level_q;
		report_d = 1'b0;
		if (running_d >= TH_FULL) begin
			if (level_q != LVL_75 || chg) begin
				level_d  = LVL_FULL;
				report_d = 1'b1;
			end
		end else if (running_d < TH_L1_HI && running_d >= TH_L1_LO
				&& (level_q < LVL_75 || chg) && level_q != LVL_75) begin
			level_d  = LVL_75;
			report_d = 1'b1;
		end else if (running_d < TH_L2_HI && running_d >= TH_L2_LO
				&& (level_q < LVL_50 || chg) && level_q != LVL_50) begin
			level_d  = LVL_50;
			report_d = 1'b1;
		end else if (running_d < TH_L3_HI && running_d >= TH_L3_LO
				&& (level_q < LVL_25 || chg) && level_q != LVL_25) begin
			level_d  = LVL_25;
			report_d = 1'b1;
		end else if (running_d < TH_L4_HI && running_d >= TH_L4_LO
				&& (level_q < LVL_10 || chg) && level_q != LVL_10) begin
			level_d  = LVL_10;
			report_d = 1'b1;
		end else if (running_d < TH_OFF_HI
				&& (level_q < LVL_OFF || chg) && level_q != LVL_OFF) begin
			level_d  = LVL_OFF;
			report_d = 1'b1;
		end
	end

	// led indication from the new level
	always_comb begin
		red_d     = red_q;
		green_d   = green_q;
		blink_d   = blink_q;
		enable_d  = enable_q;
		warning_d = warning_q;
		if (!chg && adc.discharge_latched) begin
			if (adc.led_suppress) begin
				red_d     = 1'b0;
				green_d   = 1'b0;
				blink_d   = BLINK_NONE;
				enable_d  = 1'b0;
				warning_d = 1'b0;
			end else if (level_d >= LVL_10) begin
				red_d     = 1'b1;
				green_d   = 1'b0;
				blink_d   = BLINK_FAST;
				enable_d  = 1'b1;
				warning_d = 1'b1;
			end else if (level_d == LVL_25) begin
				red_d     = 1'b1;
				green_d   = 1'b0;
				blink_d   = BLINK_SLOW;
				enable_d  = 1'b1;
				warning_d = 1'b0;
			end else if (level_d >= LVL_75) begin
				red_d     = 1'b1;
				green_d   = 1'b1;
				blink_d   = BLINK_SLOW;
				enable_d  = 1'b1;
				warning_d = 1'b0;
			end else begin
				red_d     = 1'b0;
				green_d   = 1'b1;
				blink_d   = BLINK_SLOW;
				enable_d  = 1'b1;
				warning_d = 1'b0;
			end
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RST;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	// state and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= '0;
			level_q   <= LVL_50;
			report_q  <= 1'b0;
			red_q     <= 1'b0;
			green_q   <= 1'b0;
			blink_q   <= BLINK_NONE;
			enable_q  <= 1'b0;
			warning_q <= 1'b0;
			valid_q   <= 1'b0;
		end else begin
			if (accept) begin
				running_q <= running_d;
				level_q   <= level_d;
				report_q  <= report_d;
				red_q     <= red_d;
				green_q   <= green_d;
				blink_q   <= blink_d;
				enable_q  <= enable_d;
				warning_q <= warning_d;
				valid_q   <= 1'b1;
			end else if (gauge.ready) begin
				valid_q   <= 1'b0;
			end
		end
	end

	assign gauge.valid          = valid_q;
	assign gauge.level          = level_q;
	assign gauge.report         = report_q;
	assign gauge.filtered_value = running_q;
	assign gauge.red_on         = red_q;
	assign gauge.green_on       = green_q;
	assign gauge.blink_period   = blink_q;
	assign gauge.led_enable     = enable_q;
	assign gauge.low_warning    = warning_q;

	// every accepted request yields a result in the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_q)
		else $error("no result after accepted request");

	// without charging the level only worsens, except the return to full
	a_no_improve: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !chg |=> (level_q >= $past(level_q) || level_q == LVL_FULL))
		else $error("level improved while discharging");

	// a level change is always reported
	a_change_reported: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (report_q || $stable(level_q)))
		else $error("level changed without report");

	// state holds while no request is taken
	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> ($stable(running_q) && $stable(level_q)))
		else $error("state moved without a request");

endmodule
